// File: design/hptq_pkg.sv
`timescale 1ns / 1ps
package hptq_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic CFG_NEGATIVE  = 1'b0;
  localparam logic CFG_NONFINITE = 1'b1;

  localparam logic [1:0] CLS_MAPPED    = 2'd0;
  localparam logic [1:0] CLS_NONFINITE = 2'd1;
  localparam logic [1:0] CLS_NEGATIVE  = 2'd2;
  localparam logic [1:0] CLS_UNUSED    = 2'd3;

  localparam logic [7:0] COLOR_ALPHA = 8'hFF;
  localparam int         CODE_MAX    = 255;

  // Status that one search lane reports to the top level
  typedef struct packed {
    logic       done;
    logic [7:0] code;
  } lane_status_t;

  function automatic logic f_is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_nonfinite(logic [31:0] a);
    return a[30:23] == 8'hFF;
  endfunction

  // Single-precision a < b; false when either side is NaN
  function automatic logic f_lt(logic [31:0] a, logic [31:0] b);
    logic res;
    res = 1'b0;
    if (f_is_nan(a) || f_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  function automatic logic f_is_negative(logic [31:0] a);
    return a[31] && (a[30:0] != 31'd0) && !f_is_nan(a);
  endfunction

endpackage

// File: design/hptq_lane.sv
`timescale 1ns / 1ps
module hptq_lane
  import hptq_pkg::*;
#(
  parameter int THRESHOLD_COUNT = 257,
  parameter int PW = 9,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          start,
  input  logic [31:0]   x_in,
  output lane_status_t  status
);

  typedef enum logic [2:0] {
    LN_IDLE = 3'b001,
    LN_ADDR = 3'b010,
    LN_CMP  = 3'b100
  } lane_state_t;

  lane_state_t   state;
  logic [31:0]   mem [THRESHOLD_COUNT];
  logic [31:0]   rdata;
  logic [31:0]   x;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic [PW-1:0] mid;
  logic [PW:0]   sum;
  logic [PW-1:0] lm1;

  assign sum = {1'b0, lo} + {1'b0, hi};
  assign mid = sum[PW:1];
  assign lm1 = lo - PW'(1);

  // Threshold copy for this lane: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[AW'(mid - PW'(1))];
  end

  // Binary search: issue read, then compare and halve
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      case (state)
        LN_IDLE: begin
          if (start) begin
            x     <= x_in;
            lo    <= '0;
            hi    <= PW'(THRESHOLD_COUNT + 1);
            state <= LN_ADDR;
          end
        end
        LN_ADDR: begin
          if (mid == lo) begin
            state <= LN_IDLE;
          end else begin
            state <= LN_CMP;
          end
        end
        LN_CMP: begin
          if (f_lt(x, rdata)) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
          state <= LN_ADDR;
        end
        default: state <= LN_IDLE;
      endcase
    end
  end

  // Clamp position minus one to a code
  always_comb begin
    status.done = (state == LN_IDLE);
    if (lo == '0) begin
      status.code = 8'd0;
    end else if (32'(lm1) > 32'(CODE_MAX)) begin
      status.code = 8'(CODE_MAX);
    end else begin
      status.code = 8'(lm1);
    end
  end

endmodule

// File: design/hptq_merge.sv
`timescale 1ns / 1ps
module hptq_merge
  import hptq_pkg::*;
(
  input  logic [31:0]  red,
  input  logic [31:0]  green,
  input  logic [31:0]  blue,
  input  lane_status_t red_lane,
  input  lane_status_t green_lane,
  input  lane_status_t blue_lane,
  input  logic [31:0]  negative_color,
  input  logic [31:0]  nonfinite_color,
  output logic [31:0]  word,
  output logic [1:0]   cls
);

  logic nonfin;
  logic neg;

  assign nonfin = f_is_nonfinite(red) || f_is_nonfinite(green) || f_is_nonfinite(blue);
  assign neg    = f_is_negative(red) || f_is_negative(green) || f_is_negative(blue);

  // Negative overrides non-finite, which overrides the mapped word
  always_comb begin
    if (neg) begin
      word = negative_color;
      cls  = CLS_NEGATIVE;
    end else if (nonfin) begin
      word = nonfinite_color;
      cls  = CLS_NONFINITE;
    end else begin
      word = {COLOR_ALPHA, red_lane.code, green_lane.code, blue_lane.code};
      cls  = CLS_MAPPED;
    end
  end

endmodule

// File: design/hdr_pixel_threshold_quantizer.sv
`timescale 1ns / 1ps
// Maps one RGB pixel of single-precision channels to a 0xFFRRGGBB word by
// binary search over a table of THRESHOLD_COUNT ascending thresholds, with
// three search lanes (one per channel, each with its own table copy) and a
// merge stage that applies the negative and non-finite colors. Each search
// step of a pixel word is a registered table read, then a compare; one pixel
// is searched at a time, and the next word is taken once the result has
// moved to the output.
module hdr_pixel_threshold_quantizer
  import hptq_pkg::*;
#(
  parameter int THRESHOLD_COUNT = 257
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [8:0]  table_index,
  input  logic [31:0] threshold_bits,
  input  logic [31:0] red_bits,
  input  logic [31:0] green_bits,
  input  logic [31:0] blue_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_word,
  output logic [1:0]  pixel_class,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PW = $clog2(THRESHOLD_COUNT + 2);
  localparam int AW = $clog2(THRESHOLD_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } top_state_t;

  top_state_t   state;
  logic [31:0]  negative_color;
  logic [31:0]  nonfinite_color;
  logic [31:0]  red;
  logic [31:0]  green;
  logic [31:0]  blue;
  logic         accept;
  logic         load_we;
  logic         start;
  logic [AW-1:0] waddr;
  lane_status_t red_lane;
  lane_status_t green_lane;
  lane_status_t blue_lane;
  logic         all_done;
  logic         out_free;
  logic         out_load;
  logic [31:0]  merged_word;
  logic [1:0]   merged_cls;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_we  = accept && (kind == KIND_LOAD) &&
                    ({23'd0, table_index} < 32'(THRESHOLD_COUNT));
  assign start    = accept && (kind == KIND_PIXEL);
  assign waddr    = AW'(table_index);
  assign all_done = red_lane.done && green_lane.done && blue_lane.done;
  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == ST_SEARCH) || (state == ST_HOLD)) && all_done && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      negative_color  <= '0;
      nonfinite_color <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NEGATIVE:  negative_color  <= cfg_data;
        CFG_NONFINITE: nonfinite_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the pixel for the merge stage
  always_ff @(posedge clk) begin
    if (start) begin
      red   <= red_bits;
      green <= green_bits;
      blue  <= blue_bits;
    end
  end

  hptq_lane #(.THRESHOLD_COUNT(THRESHOLD_COUNT), .PW(PW), .AW(AW)) u_red (
    .clk(clk), .rst(rst), .we(load_we), .waddr(waddr), .wdata(threshold_bits),
    .start(start), .x_in(red_bits), .status(red_lane)
  );

  hptq_lane #(.THRESHOLD_COUNT(THRESHOLD_COUNT), .PW(PW), .AW(AW)) u_green (
    .clk(clk), .rst(rst), .we(load_we), .waddr(waddr), .wdata(threshold_bits),
    .start(start), .x_in(green_bits), .status(green_lane)
  );

  hptq_lane #(.THRESHOLD_COUNT(THRESHOLD_COUNT), .PW(PW), .AW(AW)) u_blue (
    .clk(clk), .rst(rst), .we(load_we), .waddr(waddr), .wdata(threshold_bits),
    .start(start), .x_in(blue_bits), .status(blue_lane)
  );

  hptq_merge u_merge (
    .red(red), .green(green), .blue(blue),
    .red_lane(red_lane), .green_lane(green_lane), .blue_lane(blue_lane),
    .negative_color(negative_color), .nonfinite_color(nonfinite_color),
    .word(merged_word), .cls(merged_cls)
  );

  // Sequence the search and advance the result into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        pixel_word  <= merged_word;
        pixel_class <= merged_cls;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH, ST_HOLD: begin
          if (all_done) begin
            if (out_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start_search: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_SEARCH))
    else $error("pixel accepted without starting a search");

  a_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> all_done)
    else $error("lane busy while block idle");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("holding a result with an empty output register");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_class != CLS_UNUSED))
    else $error("unused pixel class code");

endmodule

// File: tb/tb_hdr_pixel_threshold_quantizer.sv
`timescale 1ns / 1ps
module tb_hdr_pixel_threshold_quantizer;
  import hptq_pkg::*;

  localparam int SLOTS      = 257;
  localparam int CYCLE_CAP  = 800000;
  localparam int DRAIN_WAIT = 60;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  cls;
  } pixel_out_t;

  typedef struct {
    logic        kind;
    logic [8:0]  idx;
    logic [31:0] thr;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic        typed;
    logic [31:0] word;
    logic [1:0]  cls;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [8:0]  table_index;
  logic [31:0] threshold_bits;
  logic [31:0] red_bits;
  logic [31:0] green_bits;
  logic [31:0] blue_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] pixel_word;
  logic [1:0]  pixel_class;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Shadow state of the quantizer
  logic [31:0] shadow_thr [0:SLOTS-1];
  logic [31:0] shadow_neg;
  logic [31:0] shadow_nonfin;

  pixel_out_t pending_pixels[$];
  int         fail_count;
  int         cycles;
  logic       calm;
  logic       hold_req;
  logic       hold_done;
  int         hold_left;
  dir_row_t   dir_rows [0:15];

  hdr_pixel_threshold_quantizer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .table_index(table_index), .threshold_bits(threshold_bits),
    .red_bits(red_bits), .green_bits(green_bits), .blue_bits(blue_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_word(pixel_word), .pixel_class(pixel_class),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic flt_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  // Float a < b via a sign-folded ordering key; unordered gives false
  function automatic logic flt_below(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (flt_nan(a) || flt_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  function automatic logic [7:0] level_of(logic [31:0] x);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = SLOTS + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (flt_below(x, shadow_thr[mid-1])) hi = mid;
      else lo = mid;
    end
    lo = lo - 1;
    if (lo < 0) lo = 0;
    if (lo > CODE_MAX) lo = CODE_MAX;
    return lo[7:0];
  endfunction

  function automatic pixel_out_t quantize_pixel(logic [31:0] r, logic [31:0] g,
                                               logic [31:0] b);
    pixel_out_t res;
    logic       neg;
    logic       nonfin;
    neg = 1'b0;
    nonfin = 1'b0;
    res.word = {COLOR_ALPHA, level_of(r), level_of(g), level_of(b)};
    res.cls  = CLS_MAPPED;
    nonfin = (r[30:23] == 8'hFF) || (g[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
    neg = flt_below(r, 32'h0) || flt_below(g, 32'h0) || flt_below(b, 32'h0);
    if (nonfin) begin
      res.word = shadow_nonfin;
      res.cls  = CLS_NONFINITE;
    end
    if (neg) begin
      res.word = shadow_neg;
      res.cls  = CLS_NEGATIVE;
    end
    return res;
  endfunction

  // Offer one word, hold it until taken, then predict
  task automatic put_word(logic k, logic [8:0] idx, logic [31:0] thr,
                          logic [31:0] r, logic [31:0] g, logic [31:0] b,
                          logic typed = 1'b0, logic [31:0] tw = 0,
                          logic [1:0] tc = CLS_MAPPED);
    pixel_out_t res;
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    table_index    <= idx;
    threshold_bits <= thr;
    red_bits       <= r;
    green_bits     <= g;
    blue_bits      <= b;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_LOAD) begin
      if (idx < SLOTS) shadow_thr[idx] = thr;
    end else begin
      res = quantize_pixel(r, g, b);
      if (typed) begin
        res.word = tw;
        res.cls  = tc;
      end
      pending_pixels.push_back(res);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_colors(logic [31:0] neg_c, logic [31:0] nonfin_c);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NEGATIVE;
    cfg_data  <= neg_c;
    @(posedge clk);
    cfg_index <= CFG_NONFINITE;
    cfg_data  <= nonfin_c;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_neg    = neg_c;
    shadow_nonfin = nonfin_c;
  endtask

  // Fill every slot: ascending narrow, ascending wide, or unordered with NaN
  task automatic load_table(int mode);
    logic [31:0] v;
    logic [31:0] t;
    v = (mode == 0) ? 32'h3A00_0000 + $urandom_range(0, 32'hFFFF)
                    : 32'h1000_0000 + $urandom_range(0, 32'hFFFF);
    for (int i = 0; i < SLOTS; i++) begin
      if (mode == 0) v = v + $urandom_range(1, 32'h4_0000);
      else if (mode == 1) v = v + $urandom_range(1, 32'h2F_0000);
      t = v;
      if (mode == 2) begin
        t = $urandom;
        if ($urandom_range(7) == 0) t = 32'h7FC0_0000 | $urandom;
        else if ($urandom_range(3) == 0) t = v;
      end
      put_word(KIND_LOAD, i[8:0], t, $urandom, $urandom, $urandom);
    end
  endtask

  function automatic logic [31:0] pick_channel(logic clean);
    logic [31:0] t;
    int          sel;
    sel = clean ? 40 : $urandom_range(0, 45);
    case (sel)
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7F80_0001 | $urandom;
      5: return 32'hFF80_0001 | $urandom;
      6: return {1'b1, 31'($urandom)};
      7: return $urandom;
      8: return 32'h7F7F_FFFF;
      default: begin
        t = shadow_thr[$urandom_range(0, SLOTS-1)];
        return t + $urandom_range(0, 4) - 2;
      end
    endcase
  endfunction

  task automatic random_items(int count, int hold_at);
    int          i;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    logic        clean;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(1) == 0) begin
          // Out-of-range slot: dropped by the block
          put_word(KIND_LOAD, 9'($urandom_range(SLOTS, 511)), $urandom,
                   $urandom, $urandom, $urandom);
        end else begin
          int s;
          s  = $urandom_range(0, SLOTS-1);
          lo = (s > 0) ? shadow_thr[s-1] : 32'h0;
          hi = (s < SLOTS-1) ? shadow_thr[s+1] : lo + 32'h100;
          t  = (hi >= lo) ? lo + ($urandom % (hi - lo + 1)) : $urandom;
          put_word(KIND_LOAD, s[8:0], t, $urandom, $urandom, $urandom);
        end
      end else begin
        clean = $urandom_range(99) < 60;
        put_word(KIND_PIXEL, 9'($urandom), $urandom, pick_channel(clean),
                 pick_channel(clean), pick_channel(clean));
      end
    end
  endtask

  // Result side: check each taken word, randomize ready, honor a hold-off
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pixel word %h class %0d", pixel_word, pixel_class);
        end else begin
          pixel_out_t exp_px;
          exp_px = pending_pixels.pop_front();
          if (pixel_word !== exp_px.word || pixel_class !== exp_px.cls) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: expected %h/%0d got %h/%0d",
                       exp_px.word, exp_px.cls, pixel_word, pixel_class);
          end
        end
      end
      if (hold_req && !hold_done && hold_left == 0) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  initial begin
    fail_count     = 0;
    cycles         = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_LOAD;
    table_index    = 0;
    threshold_bits = 0;
    red_bits       = 0;
    green_bits     = 0;
    blue_bits      = 0;
    cfg_write      = 1'b0;
    cfg_index      = CFG_NEGATIVE;
    cfg_data       = 0;
    shadow_neg     = 0;
    shadow_nonfin  = 0;
    foreach (shadow_thr[i]) shadow_thr[i] = 0;

    // Edge cases with colors still at reset
    dir_rows[0]  = '{KIND_PIXEL, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'hFF00_0000, CLS_MAPPED};
    dir_rows[1]  = '{KIND_PIXEL, 0, 0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                     1, 32'hFFFF_FFFF, CLS_MAPPED};
    dir_rows[2]  = '{KIND_PIXEL, 0, 0, 32'hBF80_0000, 32'h0, 32'h0, 1, 0, CLS_NEGATIVE};
    dir_rows[3]  = '{KIND_PIXEL, 0, 0, 32'h0, 32'h7F80_0000, 32'h0, 1, 0, CLS_NONFINITE};
    dir_rows[4]  = '{KIND_PIXEL, 0, 0, 32'hFF80_0000, 32'h0, 32'h0, 1, 0, CLS_NEGATIVE};
    dir_rows[5]  = '{KIND_PIXEL, 0, 0, 32'h0, 32'h0, 32'hFFC0_0000, 1, 0, CLS_NONFINITE};
    dir_rows[6]  = '{KIND_PIXEL, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     1, 32'hFF00_0000, CLS_MAPPED};
    dir_rows[7]  = '{KIND_PIXEL, 0, 0, 32'hBF80_0000, 32'h7F80_0000, 32'h0,
                     1, 0, CLS_NEGATIVE};
    dir_rows[8]  = '{KIND_LOAD, 9'd300, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 0, 0, CLS_MAPPED};
    dir_rows[9]  = '{KIND_LOAD, 9'h1FF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, CLS_MAPPED};
    dir_rows[10] = '{KIND_PIXEL, 0, 0, 32'h0, 32'h0, 32'h0, 1, 32'hFF00_0000, CLS_MAPPED};
    dir_rows[11] = '{KIND_PIXEL, 9'h1FF, 32'hFFFF_FFFF, 32'h3C00_0000, 32'h3D00_0000,
                     32'h3E00_0000, 0, 0, CLS_MAPPED};
    dir_rows[12] = '{KIND_PIXEL, 0, 0, 32'h3B80_0000, 32'h0000_0001, 32'h3D80_0000,
                     0, 0, CLS_MAPPED};
    dir_rows[13] = '{KIND_PIXEL, 0, 0, 32'h7FFF_FFFF, 32'h3C00_0000, 32'h0,
                     1, 0, CLS_NONFINITE};
    dir_rows[14] = '{KIND_PIXEL, 0, 0, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0,
                     1, 0, CLS_NEGATIVE};
    dir_rows[15] = '{KIND_PIXEL, 0, 0, 32'h3C80_0000, 32'h3C80_0000, 32'h3C80_0000,
                     0, 0, CLS_MAPPED};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_table(0);
    foreach (dir_rows[i])
      put_word(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].thr, dir_rows[i].r,
               dir_rows[i].g, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].word,
               dir_rows[i].cls);
    drain();

    // Phase sweep over colors and table shapes
    set_colors(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(200, 50);
    drain();
    set_colors($urandom, $urandom);
    load_table(1);
    calm = 1'b1;
    random_items(200, -1);
    drain();
    calm = 1'b0;
    set_colors(32'h0, 32'hFFFF_FFFF);
    load_table(2);
    random_items(150, -1);
    drain();
    set_colors($urandom, 32'h0);
    load_table(0);
    random_items(250, -1);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
